/* rtl/srwc_pkg.sv */
// srwc_pkg: shared constants, types and command/status structs for the
// spike rate window counter. No dependencies.
`default_nettype none
package srwc_pkg;
	localparam int CHANNELS_DEF   = 16;
	localparam int FIFO_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF  = 16;

	localparam int TIME_W    = 16;
	localparam int SPIKE_W   = 16;
	localparam int CH_OUT_W  = 4;
	localparam int CNT_OUT_W = 7;
	localparam int AVG_W     = 15;
	localparam int WIN_W     = 6;
	localparam int ACT_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_OUT = 2'd2;

	localparam logic [WIN_W-1:0] WIN_RESET = 6'd10;
	localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture tick beat, clear sum, channel 0
		logic start_ch;  // load head/fill of current channel, do append
		logic rd_head;   // issue memory read at head
		logic pop;       // drop oldest entry
		logic next_ch;   // commit channel, accumulate, advance
		logic div_start; // begin averaging divide
		logic div_step;  // one restoring-division step
	} srwc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fill_zero;
		logic expired;
		logic last_ch;
		logic div_done;
	} srwc_sts_t;
endpackage
`default_nettype wire

/* rtl/srwc_if.sv */
// srwc_if: valid/ready channel carrying a parameterized payload.
// Depends on nothing.
`default_nettype none
interface srwc_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/spike_rate_window_counter.sv */
// spike_rate_window_counter: top level; config registers, output register,
// controller and datapath. Depends on srwc_pkg, srwc_if, srwc_ctrl, srwc_dp.
//
//  channel  dir  payload                                          handshake
//  tick_in  in   {spike_bits[31:16], tick_time[15:0]}             valid/ready
//  res_out  out  {channel,spike_count,average_rate,is_average,last} valid/ready
//  cfg      in   cfg_we, cfg_idx, cfg_wdata                       write only
//
// Sequence: the idle state takes the tick beat; each active channel then
// passes S_CH, S_RD, S_CHK when entries remain, S_RD and S_CHK again per
// expired entry, then S_EMIT. Averaged mode adds an S_DIV step per quotient
// bit (19 at the default sizes) and S_OUT to load the result. The single-port
// spike time memory sets the per-entry pace of the expiry loop.
// Reset clears FIFO pointers and fills and the config registers; the memory
// is not cleared since only written entries are ever read.
// A stalled result beat holds in the output register; the walk waits there.
`default_nettype none
module spike_rate_window_counter #(
	parameter int CHANNELS   = srwc_pkg::CHANNELS_DEF,
	parameter int FIFO_DEPTH = srwc_pkg::FIFO_DEPTH_DEF,
	parameter int TIME_BITS  = srwc_pkg::TIME_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srwc_if.sink      tick_in,
	srwc_if.source    res_out,
	input  wire logic                            cfg_we,
	input  wire logic [srwc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [srwc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
	logic [srwc_pkg::WIN_W-1:0] win_q;
	logic [srwc_pkg::ACT_W-1:0] act_q;
	logic single_q;
	srwc_pkg::srwc_cmd_t cmd;
	srwc_pkg::srwc_sts_t sts;
	logic emit, emit_avg, out_busy;
	logic [srwc_pkg::CH_OUT_W-1:0] cur_channel;
	logic [srwc_pkg::CNT_OUT_W-1:0] cur_count;
	logic [srwc_pkg::AVG_W-1:0] avg_rate;
	logic out_v_q;
	logic [27:0] out_q;

	// config writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= srwc_pkg::WIN_RESET;
			act_q    <= srwc_pkg::ACT_RESET;
			single_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				srwc_pkg::REG_WIN_LEN:    win_q <= cfg_wdata;
				srwc_pkg::REG_ACTIVE_CH:  act_q <= cfg_wdata[srwc_pkg::ACT_W-1:0];
				srwc_pkg::REG_SINGLE_OUT: single_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	srwc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(tick_in.valid), .in_ready(tick_in.ready),
		.single_mode(single_q), .out_busy, .emit, .emit_avg, .cmd, .sts
	);

	srwc_dp #(.CHANNELS(CHANNELS), .FIFO_DEPTH(FIFO_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.tick_time(tick_in.data[15:0]), .spike_bits(tick_in.data[31:16]),
		.win_len(win_q), .active_channels(act_q),
		.cur_channel, .cur_count, .avg_rate
	);

	// output register: hold the beat until taken
	assign out_busy = out_v_q && !res_out.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (emit || emit_avg) out_v_q <= 1'b1;
		else if (res_out.ready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (emit) out_q <= {cur_channel, cur_count, 15'd0, 1'b0, sts.last_ch};
		else if (emit_avg) out_q <= {4'd0, 7'd0, avg_rate, 1'b1, 1'b1};
	end
	assign res_out.valid = out_v_q;
	assign res_out.data  = out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_busy |=> res_out.valid && $stable(res_out.data)) else $error("result lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit || emit_avg) |-> !out_busy) else $error("overwrite of pending result");
	a_avg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.data[1]) |-> res_out.data[0]) else $error("avg not last");
endmodule
`default_nettype wire

/* rtl/srwc_ctrl.sv */
// srwc_ctrl: sequencer for one tick: per channel append, expire loop,
// emit, then optional divide. Depends on srwc_pkg.
`default_nettype none
module srwc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              single_mode,
	input  wire logic              out_busy,
	output logic                   emit,
	output logic                   emit_avg,
	output srwc_pkg::srwc_cmd_t    cmd,
	input  wire srwc_pkg::srwc_sts_t sts
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CH    = 7'b0000010,
		S_RD    = 7'b0000100,
		S_CHK   = 7'b0001000,
		S_EMIT  = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		emit     = 1'b0;
		emit_avg = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CH;
				end
			end
			S_CH: begin
				cmd.start_ch = 1'b1;
				state_d      = S_RD;
			end
			S_RD: begin
				// read oldest entry; an empty FIFO goes straight to output
				if (sts.fill_zero) state_d = S_EMIT;
				else begin
					cmd.rd_head = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.expired) begin
					cmd.pop = 1'b1;
					state_d = S_RD;
				end else state_d = S_EMIT;
			end
			S_EMIT: begin
				if (single_mode || !out_busy) begin
					emit    = !single_mode;
					cmd.next_ch = 1'b1;
					if (sts.last_ch) begin
						if (single_mode) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else state_d = S_IDLE;
					end else state_d = S_CH;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					emit_avg = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_no_dual_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && emit_avg)) else $error("two results in one cycle");
endmodule
`default_nettype wire

/* rtl/srwc_dp.sv */
// srwc_dp: per-channel FIFO pointers, spike time memory, sum and the
// serial divider. Depends on srwc_pkg.
`default_nettype none
module srwc_dp #(
	parameter int CHANNELS   = srwc_pkg::CHANNELS_DEF,
	parameter int FIFO_DEPTH = srwc_pkg::FIFO_DEPTH_DEF,
	parameter int TIME_BITS  = srwc_pkg::TIME_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire srwc_pkg::srwc_cmd_t          cmd,
	output srwc_pkg::srwc_sts_t               sts,
	input  wire logic [srwc_pkg::TIME_W-1:0]  tick_time,
	input  wire logic [srwc_pkg::SPIKE_W-1:0] spike_bits,
	input  wire logic [srwc_pkg::WIN_W-1:0]   win_len,
	input  wire logic [srwc_pkg::ACT_W-1:0]   active_channels,
	output logic [srwc_pkg::CH_OUT_W-1:0]     cur_channel,
	output logic [srwc_pkg::CNT_OUT_W-1:0]    cur_count,
	output logic [srwc_pkg::AVG_W-1:0]        avg_rate
);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW    = $clog2(FIFO_DEPTH);
	localparam int SLOTS = 1 << PW;
	localparam int FW    = $clog2(FIFO_DEPTH + 1);
	localparam int SUMW  = $clog2(CHANNELS * FIFO_DEPTH + 1) + 8;
	localparam int NW    = $clog2(CHANNELS + 1);
	localparam int DCW   = $clog2(SUMW + 1);

	logic [TIME_BITS-1:0] now_q;
	logic [srwc_pkg::SPIKE_W-1:0] bits_q;
	logic [CW-1:0] ch_q;
	logic [NW-1:0] n_q;
	logic [PW-1:0] head_arr_q [CHANNELS];
	logic [FW-1:0] fill_arr_q [CHANNELS];
	logic [PW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [TIME_BITS-1:0] mem [CHANNELS*SLOTS];
	logic [TIME_BITS-1:0] rd_q;
	logic [SUMW-1:0] sum_q, quo_q;
	logic [NW:0] rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW+PW-1:0] wr_addr, rd_addr;
	logic spiked, full;
	logic [PW-1:0] head_app;
	logic [FW-1:0] fill_app;
	logic [PW:0] pos_sum;
	logic [PW-1:0] wr_pos;
	logic [TIME_BITS-1:0] age;
	logic [NW:0] trial;
	logic [NW-1:0] n_used;

	// advance a FIFO position, wrapping at the depth
	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
	endfunction

	always_comb begin
		if (active_channels == '0) n_used = NW'(1);
		else if (32'(active_channels) > CHANNELS) n_used = NW'(CHANNELS);
		else n_used = NW'(active_channels);
	end

	assign spiked   = (32'(ch_q) < srwc_pkg::SPIKE_W) ? bits_q[ch_q] : 1'b0;
	assign full     = fill_arr_q[ch_q] == FW'(FIFO_DEPTH);
	assign head_app = full ? next_pos(head_arr_q[ch_q]) : head_arr_q[ch_q];
	assign fill_app = full ? FW'(FIFO_DEPTH - 1) : fill_arr_q[ch_q];
	assign pos_sum  = (PW+1)'(head_app) + (PW+1)'(fill_app);
	assign wr_pos   = (pos_sum >= (PW+1)'(FIFO_DEPTH)) ?
		PW'(pos_sum - (PW+1)'(FIFO_DEPTH)) : PW'(pos_sum);
	assign wr_addr  = {ch_q, wr_pos};
	assign rd_addr  = {ch_q, head_q};
	assign age      = now_q - rd_q;
	assign trial    = {rem_q[NW-1:0], quo_q[SUMW-1]} - (NW+1)'(n_q);

	assign sts.fill_zero = fill_q == '0;
	assign sts.expired   = age > TIME_BITS'(win_len);
	assign sts.last_ch   = (NW'(ch_q) + NW'(1)) == n_q;
	assign sts.div_done  = dcnt_q == DCW'(1);

	assign cur_channel = srwc_pkg::CH_OUT_W'(ch_q);
	assign cur_count   = srwc_pkg::CNT_OUT_W'(fill_q);
	assign avg_rate    = srwc_pkg::AVG_W'(quo_q);

	always_ff @(posedge clk) begin
		if (cmd.start_ch && spiked) mem[wr_addr] <= now_q;
		if (cmd.rd_head) rd_q <= mem[rd_addr];
		if (cmd.load) begin
			now_q  <= TIME_BITS'(tick_time);
			bits_q <= spike_bits;
			n_q    <= n_used;
			sum_q  <= '0;
		end
		if (cmd.start_ch) begin
			head_q <= spiked ? head_app : head_arr_q[ch_q];
			fill_q <= spiked ? FW'(fill_app + FW'(1)) : fill_arr_q[ch_q];
		end
		if (cmd.pop) begin
			head_q <= next_pos(head_q);
			fill_q <= FW'(fill_q - FW'(1));
		end
		if (cmd.next_ch) sum_q <= SUMW'(sum_q + SUMW'(fill_q));
		if (cmd.div_start) begin
			quo_q  <= SUMW'(sum_q + SUMW'(fill_q)) << 8;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			// restoring step: one quotient bit per cycle
			if (!trial[NW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[SUMW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-1:0], quo_q[SUMW-1]};
				quo_q <= {quo_q[SUMW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			dcnt_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				head_arr_q[i] <= '0;
				fill_arr_q[i] <= '0;
			end
		end else begin
			if (cmd.load) ch_q <= '0;
			if (cmd.next_ch) begin
				head_arr_q[ch_q] <= head_q;
				fill_arr_q[ch_q] <= fill_q;
				ch_q <= sts.last_ch ? '0 : CW'(ch_q + CW'(1));
			end
			if (cmd.div_start) dcnt_q <= DCW'(SUMW);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= DCW'(dcnt_q - DCW'(1));
		end
	end
endmodule
`default_nettype wire
